@@ hdl/amed_pkg.sv @@
package amed_pkg;
  localparam int COEF_WIDTH = 33;
  typedef logic signed [COEF_WIDTH-1:0] coef_t;
  typedef struct packed {
    coef_t b0;
    coef_t b1;
    coef_t b2;
    coef_t a1;
    coef_t a2;
  } coef_set_t;

  localparam coef_set_t LP_A = '{
    b0: 33'sd519065, b1: 33'sd1038131, b2: 33'sd519065,
    a1: -33'sd1567897139, a2: 33'sd582026158};
  localparam coef_set_t LP_B = '{
    b0: 33'sd1073741824, b1: 33'sd2147483648, b2: 33'sd1073741824,
    a1: -33'sd1810774318, a2: 33'sd838515807};
  localparam coef_set_t HP = '{
    b0: 33'sd1070764338, b1: -33'sd2141528676, b2: 33'sd1070764338,
    a1: -33'sd2141520086, a2: 33'sd1067795227};
endpackage

@@ hdl/amed_mulq.sv @@
module amed_mulq #(
  parameter int SW = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  amed_pkg::coef_t          coef,
  input  logic signed [SW-1:0]     x,
  output logic                     done,
  output logic signed [SW+1:0]     prod
);
  import amed_pkg::*;
  localparam int CW = COEF_WIDTH - 1;
  localparam int AW = SW + CW + 1;
  localparam int CNTW = $clog2(CW + 1);

  logic [CW-1:0] k;
  logic [SW-1:0] m;
  logic [AW-1:0] acc;
  logic neg;
  logic busy;
  logic [CNTW-1:0] cnt;
  logic [CW-1:0] kmag;
  logic [SW-1:0] xmag;
  logic [AW-1:0] rnd;
  logic [SW+1:0] mag;

  assign kmag = coef[COEF_WIDTH-1] ? CW'(-coef) : coef[CW-1:0];
  assign xmag = x[SW-1] ? SW'(-x) : SW'(x);
  assign rnd = (acc + (AW'(1) << 29)) >> 30;
  assign mag = rnd[SW+1:0];

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      k <= kmag;
      m <= xmag;
      neg <= x[SW-1] ^ coef[COEF_WIDTH-1];
      acc <= '0;
      cnt <= CNTW'(CW);
    end else if (busy) begin
      if (cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
        prod <= neg ? -$signed(mag) : $signed(mag);
      end else begin
        acc <= (acc << 1) + (k[CW-1] ? AW'(m) : '0);
        k <= k << 1;
        cnt <= cnt - 1'b1;
      end
    end
  end
endmodule

@@ hdl/amed_isqrt.sv @@
module amed_isqrt #(
  parameter int NW = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] n,
  output logic          done,
  output logic [NW/2-1:0] root
);
  localparam int RW = NW / 2;
  localparam int CNTW = $clog2(RW + 1);
  logic [NW-1:0] rem_sh;
  logic [RW+1:0] rem;
  logic [RW-1:0] res;
  logic [CNTW-1:0] cnt;
  logic busy;
  logic [RW+1:0] trial;
  logic [RW+1:0] cand;

  assign trial = {rem[RW-1:0], rem_sh[NW-1:NW-2]};
  assign cand = {res, 2'b01};

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      rem_sh <= n;
      rem <= '0;
      res <= '0;
      cnt <= CNTW'(RW);
    end else if (busy) begin
      if (cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
        root <= res;
      end else begin
        rem_sh <= rem_sh << 2;
        if (trial >= cand) begin
          rem <= trial - cand;
          res <= {res[RW-2:0], 1'b1};
        end else begin
          rem <= trial;
          res <= {res[RW-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
      end
    end
  end
endmodule

@@ hdl/am_envelope_demodulator_top.sv @@
// Handles one I/Q sample pair at a time: in_ready is high only in idle, and a new pair is
// taken only after the previous result has been handed off on out_valid/out_ready.
// Processing is sequential at best; the bit-serial multiplier
// and the square root (one result bit per cycle) set the pace.
// Reset: synchronous, clears all filter delays and the handshake state.
module am_envelope_demodulator_top #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int STATE_WIDTH = 32,
  parameter int LOWPASS_SECTIONS = 2,
  parameter int HIGHPASS_SECTIONS = 1
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0] i_sample,
  input  logic signed [SAMPLE_WIDTH-1:0] q_sample,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [SAMPLE_WIDTH-1:0] filtered_i,
  output logic signed [SAMPLE_WIDTH-1:0] filtered_q,
  output logic signed [SAMPLE_WIDTH-1:0] audio_out
);
  import amed_pkg::*;
  localparam int SW = STATE_WIDTH;
  localparam int SH = SW - 8 - (SAMPLE_WIDTH - 1);
  localparam int LPN = 2 * LOWPASS_SECTIONS;
  localparam int HPN = 2 * HIGHPASS_SECTIONS;
  localparam int NSEC = 2 * LOWPASS_SECTIONS + HIGHPASS_SECTIONS;
  localparam int SECW = $clog2(NSEC + 1);
  localparam int LIW = $clog2(LPN);
  localparam int HIW = $clog2(HPN);
  localparam int PW = 2 * SAMPLE_WIDTH;

  localparam logic [3:0] S_IDLE = 4'd0, S_LOAD = 4'd1, S_M0 = 4'd2, S_M1 = 4'd3,
    S_M2 = 4'd4, S_M3 = 4'd5, S_M4 = 4'd6, S_SEC = 4'd7, S_SQ = 4'd8,
    S_RT = 4'd9, S_OUT = 4'd10;

  logic [3:0] state;
  logic [SECW-1:0] sec;
  logic signed [SW-1:0] lpi [LPN];
  logic signed [SW-1:0] lpq [LPN];
  logic signed [SW-1:0] hpd [HPN];
  logic signed [SAMPLE_WIDTH-1:0] xi, xq;
  logic signed [SW-1:0] x, y;
  logic signed [SW+1:0] p1, p2;
  logic signed [SW-1:0] d0, d1;
  logic signed [SAMPLE_WIDTH-1:0] fi, fq;
  logic [PW-1:0] power;
  logic [1:0] sqstep;

  logic m_start, m_done, r_start, r_done;
  coef_t m_coef;
  logic signed [SW-1:0] m_x;
  logic signed [SW+1:0] m_prod;
  logic [PW/2-1:0] root;
  coef_set_t cs;
  logic is_hp, is_q;
  logic [SECW-1:0] lsec;
  logic [SECW-1:0] hsec;
  logic [LIW-1:0] li0, li1;
  logic [HIW-1:0] hi0, hi1;

  function automatic logic signed [SW-1:0] sat(input logic signed [SW+3:0] v);
    if (v > $signed({5'b0, {(SW-1){1'b1}}})) return {1'b0, {(SW-1){1'b1}}};
    else if (v < $signed({5'b11111, {(SW-1){1'b0}}})) return {1'b1, {(SW-1){1'b0}}};
    else return SW'(v);
  endfunction

  function automatic logic signed [SAMPLE_WIDTH-1:0] tosamp(input logic signed [SW-1:0] v);
    logic [SW-1:0] mg;
    logic [SW-1:0] r;
    logic signed [SW:0] s;
    mg = v[SW-1] ? SW'(-v) : SW'(v);
    r = SW'(({1'b0, mg} + ((SW+1)'(1) << (SH - 1))) >> SH);
    s = v[SW-1] ? -$signed({1'b0, r}) : $signed({1'b0, r});
    if (s > (SW+1)'((1 << (SAMPLE_WIDTH - 1)) - 1))
      return SAMPLE_WIDTH'((1 << (SAMPLE_WIDTH - 1)) - 1);
    else if (s < -(SW+1)'(1 << (SAMPLE_WIDTH - 1)))
      return SAMPLE_WIDTH'(-(1 << (SAMPLE_WIDTH - 1)));
    else return s[SAMPLE_WIDTH-1:0];
  endfunction

  assign is_hp = sec >= SECW'(2 * LOWPASS_SECTIONS);
  assign is_q = sec >= SECW'(LOWPASS_SECTIONS) && !is_hp;
  assign lsec = is_q ? sec - SECW'(LOWPASS_SECTIONS) : sec;
  assign hsec = sec - SECW'(2 * LOWPASS_SECTIONS);
  assign li0 = LIW'({lsec, 1'b0});
  assign li1 = LIW'({lsec, 1'b1});
  assign hi0 = HIW'({hsec, 1'b0});
  assign hi1 = HIW'({hsec, 1'b1});
  assign cs = is_hp ? HP : (lsec[0] ? LP_B : LP_A);

  always_comb begin
    d0 = '0;
    d1 = '0;
    if (is_hp) begin
      d0 = hpd[hi0];
      d1 = hpd[hi1];
    end else if (is_q) begin
      d0 = lpq[li0];
      d1 = lpq[li1];
    end else begin
      d0 = lpi[li0];
      d1 = lpi[li1];
    end
  end

  always_comb begin
    unique case (state)
      S_M0: m_coef = cs.b0;
      S_M1: m_coef = cs.b1;
      S_M2: m_coef = cs.a1;
      S_M3: m_coef = cs.b2;
      default: m_coef = cs.a2;
    endcase
  end
  assign m_x = (state == S_M2 || state == S_M4) ? y : x;

  amed_mulq #(.SW(SW)) u_mul (
    .clk, .rst, .start(m_start), .coef(m_coef), .x(m_x), .done(m_done), .prod(m_prod));
  amed_isqrt #(.NW(PW)) u_sqrt (
    .clk, .rst, .start(r_start), .n(power), .done(r_done), .root(root));

  assign in_ready = state == S_IDLE;
  assign out_valid = state == S_OUT;

  always_ff @(posedge clk) begin
    m_start <= 1'b0;
    r_start <= 1'b0;
    if (rst) begin
      state <= S_IDLE;
      for (int k = 0; k < LPN; k++) begin
        lpi[k] <= '0;
        lpq[k] <= '0;
      end
      for (int k = 0; k < HPN; k++) hpd[k] <= '0;
    end else begin
      unique case (state)
        S_IDLE: if (in_valid) begin
          xi <= i_sample;
          xq <= q_sample;
          sec <= '0;
          state <= S_LOAD;
        end
        S_LOAD: begin
          x <= SW'($signed(xi)) <<< SH;
          m_start <= 1'b1;
          state <= S_M0;
        end
        S_M0: if (m_done) begin
          y <= sat((SW+4)'(m_prod) + (SW+4)'(d0));
          m_start <= 1'b1;
          state <= S_M1;
        end
        S_M1: if (m_done) begin
          p1 <= m_prod;
          m_start <= 1'b1;
          state <= S_M2;
        end
        S_M2: if (m_done) begin
          p1 <= (SW+2)'(sat((SW+4)'(p1) - (SW+4)'(m_prod) + (SW+4)'(d1)));
          m_start <= 1'b1;
          state <= S_M3;
        end
        S_M3: if (m_done) begin
          p2 <= m_prod;
          m_start <= 1'b1;
          state <= S_M4;
        end
        S_M4: if (m_done) begin
          p2 <= (SW+2)'(sat((SW+4)'(p2) - (SW+4)'(m_prod)));
          state <= S_SEC;
        end
        S_SEC: begin
          if (is_hp) begin
            hpd[hi0] <= SW'(p1);
            hpd[hi1] <= SW'(p2);
          end else if (is_q) begin
            lpq[li0] <= SW'(p1);
            lpq[li1] <= SW'(p2);
          end else begin
            lpi[li0] <= SW'(p1);
            lpi[li1] <= SW'(p2);
          end
          sec <= sec + 1'b1;
          if (sec == SECW'(LOWPASS_SECTIONS - 1)) begin
            fi <= tosamp(y);
            x <= SW'($signed(xq)) <<< SH;
            m_start <= 1'b1;
            state <= S_M0;
          end else if (sec == SECW'(2 * LOWPASS_SECTIONS - 1)) begin
            fq <= tosamp(y);
            sqstep <= '0;
            state <= S_SQ;
          end else if (sec == SECW'(NSEC - 1)) begin
            filtered_i <= fi;
            filtered_q <= fq;
            audio_out <= tosamp(y);
            state <= S_OUT;
          end else begin
            x <= y;
            m_start <= 1'b1;
            state <= S_M0;
          end
        end
        S_SQ: begin
          sqstep <= sqstep + 1'b1;
          if (sqstep == 2'd0) power <= PW'(PW'(fi) * PW'(fi));
          else if (sqstep == 2'd1) power <= power + PW'(PW'(fq) * PW'(fq));
          else begin
            r_start <= 1'b1;
            state <= S_RT;
          end
        end
        S_RT: if (r_done) begin
          x <= SW'($signed({1'b0, root})) <<< SH;
          m_start <= 1'b1;
          state <= S_M0;
        end
        S_OUT: if (out_ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
